FILE: sv/assert_macros.svh
// Assertion helpers shared by the queue, divider and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define QVD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define QVD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/qvd_pkg.sv
// ----------------------------------------------------------------------------
// qvd_pkg
// Shared widths, register indexes, reset values and the front-to-back flag word.
// ----------------------------------------------------------------------------
package qvd_pkg;

    localparam int RATE_W    = 24;
    localparam int CPR_W     = 16;
    localparam int TMO_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SPEED_W   = 18;
    localparam int DIR_W     = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 2'd2;

    localparam logic [RATE_W-1:0] TICK_RATE_RST = 24'd1000000;
    localparam logic [CPR_W-1:0]  CPR_RST       = 16'd1632;
    localparam logic [TMO_W-1:0]  TMO_RST       = 32'd100000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 18'h3FFFF;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'b11;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic             edge_seen;
        logic             stopped;
        logic             need_div;
    } t_qvd_flags;

endpackage

FILE: sv/qvd_front.sv
// ----------------------------------------------------------------------------
// qvd_front
// Takes one tick word, detects edges, timestamps them, sets direction and
// flags the stop timeout. Pushes one classified entry per tick.
// ----------------------------------------------------------------------------
module qvd_front
    import qvd_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_a,
    input  logic                  i_b,
    input  logic [TMO_W-1:0]      i_stop_timeout,
    input  logic                  i_full,
    output logic                  o_push,
    output t_qvd_flags            o_flags,
    output logic [TIMER_BITS-2:0] o_delta
);

    localparam int CMP_W = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

    logic                  r_primed;
    logic                  r_prior_a;
    logic                  r_prior_b;
    logic [TIMER_BITS-1:0] r_tick;
    logic [TIMER_BITS-1:0] r_last_edge;
    logic [DIR_W-1:0]      r_dir;

    logic                  accept;
    logic                  level_chg;
    logic [TIMER_BITS-1:0] delta;
    logic                  in_range;
    logic [DIR_W-1:0]      n_dir;
    logic [CMP_W-1:0]      idle_ext;
    logic [CMP_W-1:0]      tmo_ext;
    logic                  stop;

    always_comb begin
        accept    = i_valid && !i_full;
        level_chg = r_primed && ((i_a != r_prior_a) || (i_b != r_prior_b));
        delta     = r_tick - r_last_edge;
        in_range  = (delta != '0) && !delta[TIMER_BITS-1];
        if (level_chg) begin
            n_dir = ((r_prior_a == r_prior_b) == (i_a == i_b)) ? DIR_CCW : DIR_CW;
        end else begin
            n_dir = r_dir;
        end
        // a tick with an edge never flags a stop, so only idle ticks can time out
        idle_ext = CMP_W'(delta);
        tmo_ext  = CMP_W'(i_stop_timeout);
        stop     = !level_chg && (idle_ext > tmo_ext);
    end

    assign o_ready           = !i_full;
    assign o_push            = accept;
    assign o_flags.direction = n_dir;
    assign o_flags.edge_seen = level_chg;
    assign o_flags.stopped   = stop;
    assign o_flags.need_div  = level_chg && in_range;
    assign o_delta           = delta[TIMER_BITS-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_prior_a   <= 1'b0;
            r_prior_b   <= 1'b0;
            r_tick      <= '0;
            r_last_edge <= '0;
            r_dir       <= DIR_NONE;
        end else if (accept) begin
            r_primed <= 1'b1;
            if (!r_primed || level_chg) begin
                r_prior_a <= i_a;
                r_prior_b <= i_b;
            end
            if (level_chg) begin
                r_last_edge <= r_tick;
            end
            r_dir  <= n_dir;
            r_tick <= r_tick + 1'b1;
        end
    end

endmodule

FILE: sv/qvd_queue.sv
// ----------------------------------------------------------------------------
// qvd_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvd_queue
    import qvd_pkg::*;
#(
    parameter int DELTA_W = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_qvd_flags         i_flags,
    input  logic [DELTA_W-1:0] i_delta,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output t_qvd_flags         o_flags,
    output logic [DELTA_W-1:0] o_delta
);

    t_qvd_flags         r_flags [QUEUE_DEPTH];
    logic [DELTA_W-1:0] r_delta [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_count;

    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_flags = r_flags[r_rd];
    assign o_delta = r_delta[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_flags[r_wr] <= i_flags;
                r_delta[r_wr] <= i_delta;
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `QVD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)

endmodule

FILE: sv/qvd_div.sv
// ----------------------------------------------------------------------------
// qvd_div
// Speed from edge period: (tick_rate << FRAC) / (delta * counts_per_rev),
// one restoring quotient bit per cycle, saturated to the speed field.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvd_div
    import qvd_pkg::*;
#(
    parameter int DELTA_W   = 31,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_delta,
    input  logic [RATE_W-1:0]  i_tick_rate,
    input  logic [CPR_W-1:0]   i_cpr,
    output logic               o_busy,
    output logic               o_done,
    output logic [SPEED_W-1:0] o_speed
);

    localparam int NUM_W = RATE_W + FRAC_BITS;
    localparam int DEN_W = NUM_W + CPR_W;
    localparam int CMP_W = (DELTA_W > NUM_W) ? DELTA_W : NUM_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    t_state             r_state;
    logic               r_done;
    logic [SPEED_W-1:0] r_speed;
    logic [DELTA_W-1:0] r_delta;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_zero;
    logic               r_sat;

    logic [DEN_W:0]     shifted;
    logic               ge;
    logic [DEN_W:0]     diff;
    logic [NUM_W-1:0]   q_next;
    logic [SPEED_W-1:0] speed_res;
    logic [DEN_W-1:0]   prod;

    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        ge      = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
        q_next  = {r_q[NUM_W-2:0], ge};
        prod    = DEN_W'(NUM_W'(r_delta)) * DEN_W'(i_cpr);
        if (r_sat) begin
            speed_res = SPEED_MAX;
        end else if (r_zero) begin
            speed_res = '0;
        end else if (q_next > NUM_W'(SPEED_MAX)) begin
            speed_res = SPEED_MAX;
        end else begin
            speed_res = q_next[SPEED_W-1:0];
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_speed = r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_delta <= i_delta;
                        r_num   <= NUM_W'(i_tick_rate) << FRAC_BITS;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    // delta above the numerator means a quotient of zero
                    r_zero  <= (CMP_W'(r_delta) > CMP_W'(r_num));
                    r_sat   <= (i_cpr == '0);
                    r_den   <= prod;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                    r_num <= r_num << 1;
                    r_q   <= q_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_speed <= speed_res;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QVD_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !o_busy)
    `QVD_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

FILE: sv/qvd_back.sv
// ----------------------------------------------------------------------------
// qvd_back
// Pops classified entries, runs the period division on edges with a usable
// period, keeps the held speed and drives the registered result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvd_back
    import qvd_pkg::*;
#(
    parameter int DELTA_W   = 31,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_qvd_flags         i_q_flags,
    input  logic [DELTA_W-1:0] i_q_delta,
    output logic               o_q_pop,
    input  logic [RATE_W-1:0]  i_tick_rate,
    input  logic [CPR_W-1:0]   i_cpr,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DIR_W-1:0]   o_direction,
    output logic [SPEED_W-1:0] o_speed,
    output logic               o_edge_seen,
    output logic               o_stopped
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_qvd_flags         r_flags;
    logic [SPEED_W-1:0] r_speed;
    logic               r_out_valid;
    logic [DIR_W-1:0]   r_out_dir;
    logic [SPEED_W-1:0] r_out_speed;
    logic               r_out_edge;
    logic               r_out_stop;

    logic               out_free;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [SPEED_W-1:0] div_speed;

    assign out_free  = !r_out_valid || i_ready;
    assign div_start = (r_state == S_IDLE) && i_q_valid && i_q_flags.need_div;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && (i_q_flags.need_div || out_free);

    qvd_div #(
        .DELTA_W   (DELTA_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_delta     (i_q_delta),
        .i_tick_rate (i_tick_rate),
        .i_cpr       (i_cpr),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_speed     (div_speed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_flags.need_div) begin
                        r_flags <= i_q_flags;
                        r_state <= S_WAIT;
                    end else if (i_q_valid && out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_dir   <= i_q_flags.direction;
                        r_out_edge  <= i_q_flags.edge_seen;
                        r_out_stop  <= i_q_flags.stopped;
                        if (i_q_flags.stopped) begin
                            r_speed     <= '0;
                            r_out_speed <= '0;
                        end else begin
                            r_out_speed <= r_speed;
                        end
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_speed <= div_speed;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_dir   <= r_flags.direction;
                        r_out_edge  <= r_flags.edge_seen;
                        r_out_stop  <= r_flags.stopped;
                        r_out_speed <= r_speed;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_direction = r_out_dir;
    assign o_speed     = r_out_speed;
    assign o_edge_seen = r_out_edge;
    assign o_stopped   = r_out_stop;

    `QVD_ASSERT_IMP(a_stop_zero, i_clk, i_rst_n, r_out_valid && r_out_stop, r_out_speed == '0)
    `QVD_ASSERT_IMP(a_wait_busy, i_clk, i_rst_n, (r_state == S_WAIT) && !div_done, div_busy)

endmodule

FILE: sv/quadrature_velocity_direction_unit.sv
// ----------------------------------------------------------------------------
// quadrature_velocity_direction_unit
// Quadrature encoder direction and period-based speed meter.
// ----------------------------------------------------------------------------
// One input word per time-base tick on the s_axis channel: A and B levels.
// One result word per tick on the m_axis channel: direction and speed in
// tdata, edge and stop flags in tuser.
// Registers (tick_rate, counts_per_rev, stop_timeout) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. A tick
// without an edge reaches m_axis via the queue and the output register.
// A tick with a usable edge period runs the restoring divider, one quotient
// bit per cycle over 24 + SPEED_FRAC_BITS bits, after a setup state.
// A two-entry queue decouples tick classification from the divider, so the
// input keeps accepting while a result waits on a stalled m_axis; when the
// queue fills, s_axis_tready drops until the back end drains an entry.
// Reset (synchronous, active low) restores register defaults, clears the
// timer, edge history, direction and held speed, and empties the queue.
// ----------------------------------------------------------------------------
module quadrature_velocity_direction_unit
    import qvd_pkg::*;
#(
    parameter int TIMER_BITS      = 32,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream: [0] a_level, [1] b_level, [7:2] zero
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    // master stream: [1:0] spin_direction, [19:2] speed_q8, [23:20] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,
    // master flags: [0] edge_seen, [1] stopped
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DELTA_W = TIMER_BITS - 1;

    logic [RATE_W-1:0] r_tick_rate;
    logic [CPR_W-1:0]  r_cpr;
    logic [TMO_W-1:0]  r_stop_timeout;

    logic               push;
    t_qvd_flags         push_flags;
    logic [DELTA_W-1:0] push_delta;
    logic               q_full;
    logic               q_valid;
    t_qvd_flags         q_flags;
    logic [DELTA_W-1:0] q_delta;
    logic               q_pop;
    logic [DIR_W-1:0]   out_dir;
    logic [SPEED_W-1:0] out_speed;
    logic               out_edge;
    logic               out_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate    <= TICK_RATE_RST;
            r_cpr          <= CPR_RST;
            r_stop_timeout <= TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_RATE:      r_tick_rate    <= i_cfg_data[RATE_W-1:0];
                CFG_COUNTS_PER_REV: r_cpr          <= i_cfg_data[CPR_W-1:0];
                CFG_STOP_TIMEOUT:   r_stop_timeout <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    qvd_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_a            (s_axis_tdata[0]),
        .i_b            (s_axis_tdata[1]),
        .i_stop_timeout (r_stop_timeout),
        .i_full         (q_full),
        .o_push         (push),
        .o_flags        (push_flags),
        .o_delta        (push_delta)
    );

    qvd_queue #(
        .DELTA_W (DELTA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_flags (push_flags),
        .i_delta (push_delta),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_flags (q_flags),
        .o_delta (q_delta)
    );

    qvd_back #(
        .DELTA_W   (DELTA_W),
        .FRAC_BITS (SPEED_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_flags   (q_flags),
        .i_q_delta   (q_delta),
        .o_q_pop     (q_pop),
        .i_tick_rate (r_tick_rate),
        .i_cpr       (r_cpr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_direction (out_dir),
        .o_speed     (out_speed),
        .o_edge_seen (out_edge),
        .o_stopped   (out_stop)
    );

    assign m_axis_tdata = {4'b0000, out_speed, out_dir};
    assign m_axis_tuser = {out_stop, out_edge};

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadrature direction and speed meter.
// ----------------------------------------------------------------------------
// Feeds encoder level words as tick streams and predicts each result word
// in step with the accepted input. The predictor tracks edge time stamps,
// period-based speed and the stop timeout. Output words are checked field by
// field in order. Register settings change between phases while the block is
// idle: defaults, both extremes, zero tick rate, zero counts per rev, then
// random ones. Sender bursts, receiver stall patterns and one long output
// stall push the internal queue to full.
// ----------------------------------------------------------------------------
module testbench
    import qvd_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_BEAT   = 3;

    typedef struct packed {
        logic [DIR_W-1:0]   direction;
        logic [SPEED_W-1:0] speed;
        logic               edge_seen;
        logic               stopped;
    } t_tick_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    quadrature_velocity_direction_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // {b, a} levels in forward order
    logic [1:0] quad_seq [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    logic [7:0]    tick_queue [$];
    t_tick_reading readings_due [$];
    t_tick_reading want;

    // predictor state
    logic [RATE_W-1:0]  cfg_tick_rate = TICK_RATE_RST;
    logic [CPR_W-1:0]   cfg_cpr = CPR_RST;
    logic [TMO_W-1:0]   cfg_timeout = TMO_RST;
    logic               levels_captured = 1'b0;
    logic               last_a = 1'b0;
    logic               last_b = 1'b0;
    logic [31:0]        tick_now = '0;
    logic [31:0]        edge_stamp = '0;
    logic [DIR_W-1:0]   dir_held = DIR_NONE;
    logic [SPEED_W-1:0] speed_held = '0;

    int error_count = 0;
    int ticks_total = 0;
    int edges_total = 0;
    int stops_total = 0;
    int settings_total = 1;
    int cycles = 0;

    int burst_left = 0;
    int gap_left = 0;
    int words_taken = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int rx_mode = RX_OPEN;
    int rx_mode_left = 0;

    function automatic logic [SPEED_W-1:0] period_to_speed(input logic [31:0] delta);
        logic [63:0] scaled;
        logic [63:0] per_edge;
        logic [63:0] quot;
        scaled = 64'(cfg_tick_rate) << 8;
        per_edge = 64'(cfg_cpr);
        if (per_edge == 0)
            return SPEED_MAX;
        if (64'(delta) > scaled / per_edge)
            return '0;
        quot = scaled / (64'(delta) * per_edge);
        if (quot > 64'(SPEED_MAX))
            return SPEED_MAX;
        return quot[SPEED_W-1:0];
    endfunction

    function automatic t_tick_reading next_reading(input logic a, input logic b);
        t_tick_reading r;
        logic [31:0] delta;
        r.edge_seen = 1'b0;
        r.stopped = 1'b0;
        if (!levels_captured) begin
            levels_captured = 1'b1;
            last_a = a;
            last_b = b;
        end else if (a != last_a || b != last_b) begin
            delta = tick_now - edge_stamp;
            r.edge_seen = 1'b1;
            if (delta >= 1 && delta <= 32'h7FFF_FFFF)
                speed_held = period_to_speed(delta);
            dir_held = ((last_a == last_b) == (a == b)) ? DIR_CCW : DIR_CW;
            edge_stamp = tick_now;
            last_a = a;
            last_b = b;
            edges_total++;
        end
        if (32'(tick_now - edge_stamp) > cfg_timeout) begin
            speed_held = '0;
            r.stopped = 1'b1;
            stops_total++;
        end
        tick_now = tick_now + 1;
        ticks_total++;
        r.direction = dir_held;
        r.speed = speed_held;
        return r;
    endfunction

    task automatic check_field(input string label, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $display("%0t mismatch %s: expected %0d, actual %0d",
                     $time, label, exp_val, got_val);
            error_count++;
        end
    endtask

    // sender: bursts of words, random gaps between bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                s_axis_tdata <= tick_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(0, 12);
                    gap_left = $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                words_taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held_once && words_taken >= 700 && tick_queue.size() > 20) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(RX_OPEN, RX_BEAT);
                    rx_mode_left = $urandom_range(30, 300);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ((rx_mode_left % 8) < 5);
                endcase
            end
        end
    end

    // prediction on accept, in-order check on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                readings_due.push_back(next_reading(s_axis_tdata[0], s_axis_tdata[1]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("spin_direction", want.direction, m_axis_tdata[1:0]);
                    check_field("speed_q8", want.speed, m_axis_tdata[19:2]);
                    check_field("tdata pad", 0, m_axis_tdata[23:20]);
                    check_field("edge_seen", want.edge_seen, m_axis_tuser[0]);
                    check_field("stopped", want.stopped, m_axis_tuser[1]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, readings_due.size());
            $display("quadrature_velocity_direction_unit verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (tick_queue.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [RATE_W-1:0] rate, input logic [CPR_W-1:0] cpr,
                                input logic [TMO_W-1:0] tmo);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TICK_RATE;
        i_cfg_data <= {8'($urandom), rate};
        @(posedge i_clk);
        i_cfg_idx <= CFG_COUNTS_PER_REV;
        i_cfg_data <= {16'($urandom), cpr};
        @(posedge i_clk);
        i_cfg_idx <= CFG_STOP_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_tick_rate = rate;
        cfg_cpr = cpr;
        cfg_timeout = tmo;
        settings_total++;
        @(negedge i_clk);
    endtask

    // encoder motion: Gray steps with random dwell, reversals and double flips
    task automatic queue_motion(input int ticks, input int hold_max, input int idle_max);
        int pos;
        int step;
        int hold;
        int pushed;
        int pick;
        pos = $urandom_range(0, 3);
        step = $urandom_range(0, 1) ? 1 : 3;
        pushed = 0;
        while (pushed < ticks) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(1, idle_max)
                                               : $urandom_range(1, hold_max);
            repeat (hold) tick_queue.push_back({6'd0, quad_seq[pos]});
            pushed += hold;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                step = 4 - step;
            if (pick == 1)
                pos = (pos + 2) % 4;
            else
                pos = (pos + step) % 4;
        end
    endtask

    task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [CPR_W-1:0] cpr,
                             input logic [TMO_W-1:0] tmo, input int ticks);
        int hold_max;
        hold_max = $urandom_range(1, 12);
        wait_idle();
        program_regs(rate, cpr, tmo);
        queue_motion(ticks, hold_max, (tmo < 60) ? int'(tmo) + 8 : hold_max * 4);
    endtask

    // {b, a}: capture, hold, single flips both ways, double flips, dwell
    logic [1:0] opening [25] = '{2'd3, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd3, 2'd3, 2'd3,
                                 2'd2, 2'd1, 2'd1, 2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2,
                                 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd3};

    initial begin
        logic [RATE_W-1:0] rate;
        logic [CPR_W-1:0]  cpr;
        logic [TMO_W-1:0]  tmo;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (opening[k])
            tick_queue.push_back({6'd0, opening[k]});

        run_phase(24'hFF_FFFF, 16'd1, 32'd0, 120);
        run_phase(24'd1, 16'hFFFF, 32'hFFFF_FFFF, 120);
        run_phase(24'd0, 16'($urandom_range(1, 16'hFFFF)), 32'd30, 80);
        run_phase(24'($urandom_range(1, 24'hFF_FFFF)), 16'd0, 32'd30, 80);
        repeat (8) begin
            if ($urandom_range(0, 2) == 0) begin
                rate = 24'($urandom_range(1, 24'hFF_FFFF));
                cpr = 16'($urandom_range(1, 16'hFFFF));
            end else begin
                rate = 24'($urandom_range(1000, 200000));
                cpr = 16'($urandom_range(4, 2048));
            end
            tmo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
            run_phase(rate, cpr, tmo, 175);
        end

        wait_idle();
        repeat (50) @(negedge i_clk);
        $display("covered %0d ticks with %0d edges and %0d stop events", ticks_total,
                 edges_total, stops_total);
        $display("over %0d register settings, including one %0d-cycle output stall",
                 settings_total, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("quadrature_velocity_direction_unit verification clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("quadrature_velocity_direction_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/qvd_pkg.sv
sv/qvd_front.sv
sv/qvd_queue.sv
sv/qvd_div.sv
sv/qvd_back.sv
sv/quadrature_velocity_direction_unit.sv
bench/testbench.sv
